// ===== design/f2i_pkg.sv =====
package f2i_pkg;

    localparam logic [2:0] FMT_U32 = 3'd4;
    localparam logic [2:0] FMT_S32 = 3'd5;

    localparam logic [1:0] RM_NEAREST = 2'd0;
    localparam logic [1:0] RM_DOWN    = 2'd1;
    localparam logic [1:0] RM_UP      = 2'd2;
    localparam logic [1:0] RM_ZERO    = 2'd3;

    // Decoded operand, handed from stage 1 to stage 2
    typedef struct packed {
        logic        neg;
        logic        bad;      // NaN, infinity, format or overflow failure
        logic        is_s32;
        logic        left;     // shift left (exponent at or above 150)
        logic [5:0]  amt;      // shift amount
        logic [23:0] man;
        logic [1:0]  mode;
    } f2i_dec_t;

    // Aligned magnitude with rounding bits, stage 2 to stage 3
    typedef struct packed {
        logic        neg;
        logic        bad;
        logic        is_s32;
        logic [32:0] ip;       // integer part, up to 2^33 - 1
        logic        half_bit; // first dropped bit
        logic        sticky;   // any lower dropped bit
        logic [1:0]  mode;
    } f2i_aln_t;

endpackage

// ===== design/float32_to_integer_convert_core.sv =====
// Float32 to 32-bit integer converter.
// Each accepted word passes through the decode, align and round registers in that order.
// Throughput: one word per cycle unless m_ready stalls the output; stages decode, align, round each registered.
// Reset: aresetn synchronous active low clears all stage valid bits.
module float32_to_integer_convert_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_source_bits,
    input  logic [2:0]  s_dest_format,
    input  logic [1:0]  s_round_mode,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_converted,
    output logic        m_ok
);
    import f2i_pkg::*;

    f2i_dec_t    dec_c, dec_reg;
    f2i_aln_t    aln_c, aln_reg;
    logic [31:0] conv_c, conv_reg;
    logic        ok_c, ok_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;

    f2i_decode u_dec (
        .source_bits (s_source_bits),
        .dest_format (s_dest_format),
        .round_mode  (s_round_mode),
        .dec         (dec_c)
    );

    f2i_align u_aln (.dec(dec_reg), .aln(aln_c));

    f2i_round u_rnd (.aln(aln_reg), .converted(conv_c), .ok(ok_c));

    // Advance each stage when the one after it is empty or moving
    assign adv3    = ~v3_reg | m_ready;
    assign adv2    = ~v2_reg | adv3;
    assign adv1    = ~v1_reg | adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // Hold payload on stall
    always_ff @(posedge aclk) begin
        if (adv1) dec_reg <= dec_c;
        if (adv2) aln_reg <= aln_c;
        if (adv3) begin
            conv_reg <= conv_c;
            ok_reg   <= ok_c;
        end
    end

    assign m_valid     = v3_reg;
    assign m_converted = conv_reg;
    assign m_ok        = ok_reg;

    a_zero_when_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_converted == 32'd0)
        else $error("failed conversion with nonzero value");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !m_ready |=> v3_reg && $stable(conv_reg))
        else $error("output stage lost word on stall");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted word not captured");

endmodule

// ===== design/f2i_decode.sv =====
module f2i_decode (
    input  logic                  [31:0] source_bits,
    input  logic                  [2:0]  dest_format,
    input  logic                  [1:0]  round_mode,
    output f2i_pkg::f2i_dec_t            dec
);
    import f2i_pkg::*;

    logic [7:0] ex;
    logic [8:0] eff;

    // Split the fields and work out the shift direction and amount
    always_comb begin
        ex         = source_bits[30:23];
        eff        = (ex == 8'd0) ? 9'd1 : {1'b0, ex};
        dec.neg    = source_bits[31];
        dec.is_s32 = (dest_format == FMT_S32);
        dec.mode   = round_mode;
        dec.man    = {(ex != 8'd0), source_bits[22:0]};
        dec.left   = (eff >= 9'd150);
        if (dec.left) begin
            dec.amt = (eff - 9'd150 > 9'd32) ? 6'd33 : 6'((eff - 9'd150));
        end else begin
            dec.amt = (9'd150 - eff > 9'd26) ? 6'd26 : 6'((9'd150 - eff));
        end
        dec.bad = (ex == 8'hFF)
                || !(dest_format == FMT_U32 || dest_format == FMT_S32)
                || (dec.left && dec.amt > 6'd32);
    end

endmodule

// ===== design/f2i_align.sv =====
module f2i_align (
    input  f2i_pkg::f2i_dec_t dec,
    output f2i_pkg::f2i_aln_t aln
);
    import f2i_pkg::*;

    logic [58:0] wide;
    logic [49:0] frac;

    // Shift the significand into integer and fraction parts
    always_comb begin
        wide       = 59'(dec.man) << dec.amt[5:0];
        frac       = {dec.man, 26'd0} >> dec.amt[4:0];
        aln.neg    = dec.neg;
        aln.is_s32 = dec.is_s32;
        aln.mode   = dec.mode;
        // Flag magnitudes that spill past the 33-bit integer part
        aln.bad    = dec.bad | (dec.left & (|wide[58:33]));
        if (dec.left) begin
            aln.ip       = wide[32:0];
            aln.half_bit = 1'b0;
            aln.sticky   = 1'b0;
        end else begin
            aln.ip       = {9'd0, frac[49:26]};
            aln.half_bit = frac[25];
            aln.sticky   = |frac[24:0];
        end
    end

endmodule

// ===== design/f2i_round.sv =====
module f2i_round (
    input  f2i_pkg::f2i_aln_t        aln,
    output logic              [31:0] converted,
    output logic                     ok
);
    import f2i_pkg::*;

    logic        up;
    logic        inexact;
    logic [33:0] mag;
    logic        fit;
    logic [31:0] neg_val;

    // Round the magnitude, range-check and apply the sign
    always_comb begin
        inexact = aln.half_bit | aln.sticky;
        case (aln.mode)
            RM_DOWN: up = aln.neg & inexact;
            RM_UP:   up = ~aln.neg & inexact;
            RM_ZERO: up = 1'b0;
            default: up = aln.half_bit & (aln.sticky | aln.ip[0]);
        endcase
        mag = {1'b0, aln.ip} + {33'd0, up};
        if (aln.is_s32) begin
            fit = aln.neg ? (mag <= 34'h080000000) : (mag < 34'h080000000);
        end else begin
            fit = aln.neg ? (mag == 34'd0) : (mag < 34'h100000000);
        end
        ok        = fit & ~aln.bad;
        neg_val   = 32'd0 - mag[31:0];
        converted = ok ? (aln.neg ? neg_val : mag[31:0]) : 32'd0;
    end

endmodule
